// ----- hw/rtl/random_bar_gain_gate_assert.svh -----
// Assertion macros for the random bar gain gate
`ifndef RANDOM_BAR_GAIN_GATE_ASSERT_SVH
`define RANDOM_BAR_GAIN_GATE_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define RBG_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbg check failed");

// next-cycle implication, clocked on clock, off during reset
`define RBG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rbg check failed");

`endif

// ----- hw/rtl/rbg_pkg.sv -----
// Shared types and constants for the random bar gain gate
package rbg_pkg;

   localparam int CHANNELS          = 2;
   localparam int FADE_MIN_FRACTION = 655;

   localparam int SAMPLE_W    = 24;
   localparam int GAIN_W      = 25;
   localparam int GAIN_FRAC_W = 24;
   localparam int STEP_W      = 26;
   localparam int LEFT_W      = 28;
   localparam int BAR_W       = 31;
   localparam int FPB_W       = 23;
   localparam int GRAN_W      = 6;
   localparam int WEIGHT_W    = 7;
   localparam int FRAC_W      = 17;
   localparam int FRAC_SHIFT  = 16;
   localparam int RNG_W       = 32;
   localparam int DRAW_W      = 24;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   localparam int CHOICE_W = DRAW_W + 9;
   localparam int TGT_W    = DRAW_W + WEIGHT_W;
   localparam int FRACP_W  = DRAW_W + FRAC_SHIFT;
   localparam int FG_W     = FPB_W + GRAN_W;
   localparam int LP_W     = FG_W + FRAC_W;
   localparam int LEN_W    = LP_W - FRAC_SHIFT;

   localparam int LANE_PROD_W = SAMPLE_W + GAIN_W + 1;

   localparam int DIV_W      = 32;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic [GAIN_W-1:0]   UNITY      = 25'd16777216;
   localparam logic [GAIN_W-1:0]   HALF_GAIN  = 25'd8388608;
   localparam logic [GAIN_W-1:0]   SNAP_LOW   = 25'd16777;
   localparam logic [GAIN_W-1:0]   SNAP_HIGH  = 25'd16760439;
   localparam logic [RNG_W-1:0]    LCG_MUL    = 32'd1664525;
   localparam logic [RNG_W-1:0]    LCG_ADD    = 32'd1013904223;
   localparam logic [RNG_W-1:0]    SEED_RESET = 32'd1;
   localparam logic [GRAN_W-1:0]   GRAN_MAX   = 6'd32;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 7'd100;
   localparam logic [WEIGHT_W-1:0] PERCENT_SCALE = 7'd100;
   localparam logic [FRAC_W-1:0]   FRAC_ONE   = 17'd65536;
   localparam logic [FRAC_W-1:0]   FADE_MIN_Q = FRAC_W'(FADE_MIN_FRACTION);
   localparam logic [LP_W-1:0]     ROUND_HALF = LP_W'(32768);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRANULARITY       = 3'd0,
      CSR_MAINTAIN_WEIGHT   = 3'd1,
      CSR_FADE_WEIGHT       = 3'd2,
      CSR_CUT_WEIGHT        = 3'd3,
      CSR_FADE_MAX_FRACTION = 3'd4,
      CSR_BIAS_PERCENT      = 3'd5,
      CSR_MUTE              = 3'd6,
      CSR_RNG_SEED          = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GRAN_W-1:0]   granularity;
      logic [WEIGHT_W-1:0] maintain_weight;
      logic [WEIGHT_W-1:0] fade_weight;
      logic [WEIGHT_W-1:0] cut_weight;
      logic [FRAC_W-1:0]   fade_max_fraction;
      logic [WEIGHT_W-1:0] bias_percent;
      logic                mute;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      granularity:       6'd1,
      maintain_weight:   7'd100,
      fade_weight:       7'd0,
      cut_weight:        7'd0,
      fade_max_fraction: 17'd65536,
      bias_percent:      7'd50,
      mute:              1'b0
   };

   typedef struct packed {
      logic             load;
      logic [RNG_W-1:0] value;
   } seed_type;

   typedef struct packed {
      logic accept;
      logic out_free;
   } seq_ctrl_type;

   typedef struct packed {
      logic              idle;
      logic              done;
      logic [GAIN_W-1:0] gain;
   } seq_stat_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [LEFT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [LEFT_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- hw/rtl/random_bar_gain_gate.sv -----
// Top level of the random bar gain gate: config, lanes and result register
//
//  port group | direction | beat contents
//  req_*      | in        | bar_start, bar_index, frames_per_bar, two samples
//  rsp_*      | out       | two scaled samples, applied_gain
//  csr_*      | in        | register write: index and data, no read-back
//
// A beat without bar start passes the ramp, multiply and output states from accept to
// next accept; a bar start adds the granularity check, a transition the draw and choice
// states, and a fade the length states and the step division. The shared divider, two
// bits a cycle, does both divisions. Reset is synchronous; there is no clearing pass.
// A stalled result waits in its register while the next beat is taken in.
`include "random_bar_gain_gate_assert.svh"

module random_bar_gain_gate (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_bar_start,
   input  logic        [rbg_pkg::BAR_W-1:0]       req_bar_index,
   input  logic        [rbg_pkg::FPB_W-1:0]       req_frames_per_bar,
   input  logic signed [rbg_pkg::SAMPLE_W-1:0]    req_in_sample_a,
   input  logic signed [rbg_pkg::SAMPLE_W-1:0]    req_in_sample_b,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [rbg_pkg::SAMPLE_W-1:0]    rsp_out_sample_a,
   output logic signed [rbg_pkg::SAMPLE_W-1:0]    rsp_out_sample_b,
   output logic        [rbg_pkg::GAIN_W-1:0]      rsp_applied_gain,
   input  logic                                   csr_write_en,
   input  logic        [rbg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [rbg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rbg_pkg::cfg_type                        cfg_ff, cfg_in;
   rbg_pkg::seed_type                       seed;
   rbg_pkg::seq_ctrl_type                   ctrl;
   rbg_pkg::seq_stat_type                   stat;
   logic signed [rbg_pkg::SAMPLE_W-1:0]     sample_a_ff, sample_a_in;
   logic signed [rbg_pkg::SAMPLE_W-1:0]     sample_b_ff, sample_b_in;
   logic signed [rbg_pkg::SAMPLE_W-1:0]     lane_a_res, lane_b_res;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [rbg_pkg::SAMPLE_W-1:0]     out_a_ff, out_a_in;
   logic signed [rbg_pkg::SAMPLE_W-1:0]     out_b_ff, out_b_in;
   logic        [rbg_pkg::GAIN_W-1:0]       out_gain_ff, out_gain_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (rbg_pkg::csr_index_type'(csr_index))
            rbg_pkg::CSR_GRANULARITY:
               cfg_in.granularity = csr_wdata[rbg_pkg::GRAN_W-1:0];
            rbg_pkg::CSR_MAINTAIN_WEIGHT:
               cfg_in.maintain_weight = csr_wdata[rbg_pkg::WEIGHT_W-1:0];
            rbg_pkg::CSR_FADE_WEIGHT:
               cfg_in.fade_weight = csr_wdata[rbg_pkg::WEIGHT_W-1:0];
            rbg_pkg::CSR_CUT_WEIGHT:
               cfg_in.cut_weight = csr_wdata[rbg_pkg::WEIGHT_W-1:0];
            rbg_pkg::CSR_FADE_MAX_FRACTION:
               cfg_in.fade_max_fraction = csr_wdata[rbg_pkg::FRAC_W-1:0];
            rbg_pkg::CSR_BIAS_PERCENT:
               cfg_in.bias_percent = csr_wdata[rbg_pkg::WEIGHT_W-1:0];
            rbg_pkg::CSR_MUTE:
               cfg_in.mute = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign seed.load  = csr_write_en && (csr_index == rbg_pkg::CSR_RNG_SEED);
   assign seed.value = csr_wdata[rbg_pkg::RNG_W-1:0];

   assign req_stall     = !stat.idle;
   assign ctrl.accept   = req_valid && !req_stall;
   assign ctrl.out_free = !rsp_valid_ff || !rsp_stall;

   assign sample_a_in = ctrl.accept ? req_in_sample_a : sample_a_ff;
   assign sample_b_in = ctrl.accept ? req_in_sample_b : sample_b_ff;

   rbg_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .seed           (seed),
      .ctrl           (ctrl),
      .bar_start      (req_bar_start),
      .bar_index      (req_bar_index),
      .frames_per_bar (req_frames_per_bar),
      .stat           (stat)
   );

   rbg_lane u_lane_a (
      .clock  (clock),
      .sample (sample_a_ff),
      .gain   (stat.gain),
      .scaled (lane_a_res)
   );

   if (rbg_pkg::CHANNELS >= 2) begin : g_lane_b
      rbg_lane u_lane_b (
         .clock  (clock),
         .sample (sample_b_ff),
         .gain   (stat.gain),
         .scaled (lane_b_res)
      );
   end else begin : g_no_lane_b
      assign lane_b_res = '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_gain_in  = out_gain_ff;
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         out_a_in     = lane_a_res;
         out_b_in     = lane_b_res;
         out_gain_in  = stat.gain;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= rbg_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_a_ff <= sample_a_in;
      sample_b_ff <= sample_b_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_gain_ff <= out_gain_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample_a = out_a_ff;
   assign rsp_out_sample_b = out_b_ff;
   assign rsp_applied_gain = out_gain_ff;

   `RBG_ASSERT_NEXT(a_busy_after_accept, ctrl.accept, req_stall)
   `RBG_ASSERT_SAME(a_gain_bound, rsp_valid, rsp_applied_gain <= rbg_pkg::UNITY)
   `RBG_ASSERT_NEXT(a_mute_zero_gain, stat.done && cfg_ff.mute, rsp_applied_gain == '0)

endmodule

// ----- hw/rtl/rbg_divu.sv -----
// Shared unsigned divider, restoring, two quotient bits per cycle
module rbg_divu (
   input  logic                 clock,
   input  logic                 reset,
   input  rbg_pkg::div_req_type req,
   output rbg_pkg::div_rsp_type rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [rbg_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [rbg_pkg::DIV_W-1:0]           quo_ff, quo_in;
   logic [rbg_pkg::LEFT_W-1:0]          rem_ff, rem_in;
   logic [rbg_pkg::LEFT_W-1:0]          dsr_ff, dsr_in;

   always_comb begin
      logic [rbg_pkg::LEFT_W:0] trial;
      trial   = '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         for (int i = 0; i < rbg_pkg::DIV_STEPS; i++) begin
            trial  = {rem_in, quo_in[rbg_pkg::DIV_W-1]};
            quo_in = {quo_in[rbg_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_ff}) begin
               rem_in    = rbg_pkg::LEFT_W'(trial - {1'b0, dsr_ff});
               quo_in[0] = 1'b1;
            end else begin
               rem_in = trial[rbg_pkg::LEFT_W-1:0];
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rbg_pkg::DIV_CNT_W'(rbg_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp = '{done: done_ff, quotient: quo_ff, remainder: rem_ff};

endmodule

// ----- hw/rtl/rbg_seq.sv -----
// Bar sequencer: random draws, gain state, fade set-up and ramp
module rbg_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  rbg_pkg::cfg_type              cfg,
   input  rbg_pkg::seed_type             seed,
   input  rbg_pkg::seq_ctrl_type         ctrl,
   input  logic                          bar_start,
   input  logic [rbg_pkg::BAR_W-1:0]     bar_index,
   input  logic [rbg_pkg::FPB_W-1:0]     frames_per_bar,
   output rbg_pkg::seq_stat_type         stat
);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_MOD    = 14'b00000000000010,
      S_DRAW   = 14'b00000000000100,
      S_CHOOSE = 14'b00000000001000,
      S_DECIDE = 14'b00000000010000,
      S_TARGET = 14'b00000000100000,
      S_FRAC   = 14'b00000001000000,
      S_LEN1   = 14'b00000010000000,
      S_LEN2   = 14'b00000100000000,
      S_LEN3   = 14'b00001000000000,
      S_DIV    = 14'b00010000000000,
      S_RAMP   = 14'b00100000000000,
      S_MUL    = 14'b01000000000000,
      S_OUT    = 14'b10000000000000
   } state_type;

   state_type                            state_ff, state_in;
   logic [rbg_pkg::RNG_W-1:0]            rng_ff, rng_in;
   logic [rbg_pkg::GAIN_W-1:0]           gain_ff, gain_in;
   logic                                 target_ff, target_in;
   logic [rbg_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [rbg_pkg::LEFT_W-1:0]           left_ff, left_in;
   logic [rbg_pkg::FPB_W-1:0]            fpb_ff, fpb_in;
   logic [rbg_pkg::CHOICE_W-1:0]         choice_ff, choice_in;
   logic                                 fade_sel_ff, fade_sel_in;
   logic [rbg_pkg::FRAC_W-1:0]           q_ff, q_in;
   logic [rbg_pkg::FG_W-1:0]             fg_ff, fg_in;
   logic [rbg_pkg::LP_W-1:0]             len_prod_ff, len_prod_in;
   logic                                 neg_ff, neg_in;

   logic [rbg_pkg::GRAN_W-1:0]           gran_c;
   logic [rbg_pkg::WEIGHT_W-1:0]         m_c, f_c, c_c, bias_c, m_eff;
   logic [8:0]                           sum, sum_eff;
   logic [7:0]                           mf;
   logic [rbg_pkg::FRAC_W-1:0]           hi_c, span;
   logic [rbg_pkg::DRAW_W-1:0]           draw_u;
   logic [rbg_pkg::RNG_W-1:0]            lcg_next;
   logic [rbg_pkg::CHOICE_W-1:0]         choice_prod, maint_limit, fade_limit;
   logic                                 target_hit;
   logic [rbg_pkg::FRACP_W-1:0]          frac_prod;
   logic [rbg_pkg::FRAC_W-1:0]           frac_q;
   logic [rbg_pkg::LP_W-1:0]             len_sum;
   logic [rbg_pkg::LEN_W-1:0]            len_full;
   logic [rbg_pkg::LEFT_W-1:0]           left_new, left_dec;
   logic [rbg_pkg::GAIN_W-1:0]           tgt_gain, snap_gain;
   logic [rbg_pkg::STEP_W-1:0]           diff, diff_mag, quo_step;
   rbg_pkg::div_req_type                 div_req;
   rbg_pkg::div_rsp_type                 div_rsp;

   function automatic logic [rbg_pkg::WEIGHT_W-1:0] clamp_w(
      input logic [rbg_pkg::WEIGHT_W-1:0] v);
      return (v > rbg_pkg::WEIGHT_MAX) ? rbg_pkg::WEIGHT_MAX : v;
   endfunction

   always_comb begin
      if (cfg.granularity == '0) begin
         gran_c = rbg_pkg::GRAN_W'(1);
      end else if (cfg.granularity > rbg_pkg::GRAN_MAX) begin
         gran_c = rbg_pkg::GRAN_MAX;
      end else begin
         gran_c = cfg.granularity;
      end
      if (cfg.fade_max_fraction < rbg_pkg::FADE_MIN_Q) begin
         hi_c = rbg_pkg::FADE_MIN_Q;
      end else if (cfg.fade_max_fraction > rbg_pkg::FRAC_ONE) begin
         hi_c = rbg_pkg::FRAC_ONE;
      end else begin
         hi_c = cfg.fade_max_fraction;
      end
   end

   assign m_c     = clamp_w(cfg.maintain_weight);
   assign f_c     = clamp_w(cfg.fade_weight);
   assign c_c     = clamp_w(cfg.cut_weight);
   assign bias_c  = clamp_w(cfg.bias_percent);
   assign sum     = 9'(m_c) + 9'(f_c) + 9'(c_c);
   assign sum_eff = (sum == '0) ? 9'd1 : sum;
   assign m_eff   = (sum == '0) ? rbg_pkg::WEIGHT_W'(1) : m_c;
   assign mf      = 8'(m_c) + 8'(f_c);
   assign span    = hi_c - rbg_pkg::FADE_MIN_Q;

   assign draw_u   = rng_ff[rbg_pkg::DRAW_W-1:0];
   assign lcg_next = rng_ff * rbg_pkg::LCG_MUL + rbg_pkg::LCG_ADD;

   assign choice_prod = rbg_pkg::CHOICE_W'(draw_u) * rbg_pkg::CHOICE_W'(sum_eff);
   assign maint_limit = rbg_pkg::CHOICE_W'({m_eff, 24'd0});
   assign fade_limit  = rbg_pkg::CHOICE_W'({mf, 24'd0});
   assign target_hit  = (rbg_pkg::TGT_W'(draw_u) * rbg_pkg::TGT_W'(rbg_pkg::PERCENT_SCALE))
                        < rbg_pkg::TGT_W'({bias_c, 24'd0});

   assign frac_prod = rbg_pkg::FRACP_W'(draw_u) * rbg_pkg::FRACP_W'(span);
   assign frac_q    = rbg_pkg::FADE_MIN_Q
                      + rbg_pkg::FRAC_W'(frac_prod[rbg_pkg::FRACP_W-1:rbg_pkg::DRAW_W]);

   assign len_sum  = len_prod_ff + rbg_pkg::ROUND_HALF;
   assign len_full = (len_prod_ff > rbg_pkg::LP_W'(rbg_pkg::FRAC_ONE))
                     ? len_sum[rbg_pkg::LP_W-1:rbg_pkg::FRAC_SHIFT]
                     : rbg_pkg::LEN_W'(1);
   assign left_new = (len_full[rbg_pkg::LEFT_W-1:0] == '0)
                     ? rbg_pkg::LEFT_W'(1) : len_full[rbg_pkg::LEFT_W-1:0];
   assign left_dec = left_ff - 1'b1;

   assign tgt_gain  = target_ff ? rbg_pkg::UNITY : '0;
   assign snap_gain = (gain_ff > rbg_pkg::SNAP_LOW && gain_ff < rbg_pkg::SNAP_HIGH)
                      ? ((gain_ff < rbg_pkg::HALF_GAIN) ? '0 : rbg_pkg::UNITY)
                      : gain_ff;
   assign diff      = rbg_pkg::STEP_W'({1'b0, tgt_gain}) - rbg_pkg::STEP_W'({1'b0, gain_ff});
   assign diff_mag  = diff[rbg_pkg::STEP_W-1] ? (rbg_pkg::STEP_W'(0) - diff) : diff;
   assign quo_step  = div_rsp.quotient[rbg_pkg::STEP_W-1:0];

   always_comb begin
      div_req.start    = (ctrl.accept && bar_start) || (state_ff == S_LEN3);
      div_req.dividend = (state_ff == S_LEN3) ? rbg_pkg::DIV_W'(diff_mag)
                                              : rbg_pkg::DIV_W'(bar_index);
      div_req.divisor  = (state_ff == S_LEN3) ? left_new : rbg_pkg::LEFT_W'(gran_c);
   end

   rbg_divu u_divu (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in    = state_ff;
      rng_in      = rng_ff;
      gain_in     = gain_ff;
      target_in   = target_ff;
      step_in     = step_ff;
      left_in     = left_ff;
      fpb_in      = fpb_ff;
      choice_in   = choice_ff;
      fade_sel_in = fade_sel_ff;
      q_in        = q_ff;
      fg_in       = fg_ff;
      len_prod_in = len_prod_ff;
      neg_in      = neg_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.accept) begin
               fpb_in   = frames_per_bar;
               state_in = bar_start ? S_MOD : S_RAMP;
            end
         end
         S_MOD: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0 && left_ff == '0) begin
                  gain_in  = snap_gain;
                  state_in = S_DRAW;
               end else begin
                  state_in = S_RAMP;
               end
            end
         end
         S_DRAW: begin
            rng_in   = lcg_next;
            state_in = S_CHOOSE;
         end
         S_CHOOSE: begin
            choice_in = choice_prod;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            if (choice_ff < maint_limit) begin
               state_in = S_RAMP;
            end else begin
               rng_in      = lcg_next;
               fade_sel_in = (choice_ff < fade_limit);
               state_in    = S_TARGET;
            end
         end
         S_TARGET: begin
            target_in = target_hit;
            if (fade_sel_ff) begin
               if (fpb_ff == '0) begin
                  state_in = S_RAMP;
               end else if (hi_c > rbg_pkg::FADE_MIN_Q) begin
                  rng_in   = lcg_next;
                  state_in = S_FRAC;
               end else begin
                  q_in     = rbg_pkg::FADE_MIN_Q;
                  state_in = S_LEN1;
               end
            end else begin
               gain_in  = target_hit ? rbg_pkg::UNITY : '0;
               left_in  = '0;
               step_in  = '0;
               state_in = S_RAMP;
            end
         end
         S_FRAC: begin
            q_in     = frac_q;
            state_in = S_LEN1;
         end
         S_LEN1: begin
            fg_in    = rbg_pkg::FG_W'(fpb_ff) * rbg_pkg::FG_W'(gran_c);
            state_in = S_LEN2;
         end
         S_LEN2: begin
            len_prod_in = rbg_pkg::LP_W'(fg_ff) * rbg_pkg::LP_W'(q_ff);
            state_in    = S_LEN3;
         end
         S_LEN3: begin
            left_in  = left_new;
            neg_in   = diff[rbg_pkg::STEP_W-1];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               step_in  = neg_ff ? (rbg_pkg::STEP_W'(0) - quo_step) : quo_step;
               state_in = S_RAMP;
            end
         end
         S_RAMP: begin
            if (left_ff != '0) begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  gain_in = tgt_gain;
                  step_in = '0;
               end else begin
                  gain_in = gain_ff + step_ff[rbg_pkg::GAIN_W-1:0];
               end
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (ctrl.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (seed.load) begin
         rng_in = seed.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rng_ff    <= rbg_pkg::SEED_RESET;
         gain_ff   <= rbg_pkg::UNITY;
         target_ff <= 1'b1;
         step_ff   <= '0;
         left_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rng_ff    <= rng_in;
         gain_ff   <= gain_in;
         target_ff <= target_in;
         step_ff   <= step_in;
         left_ff   <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      fpb_ff      <= fpb_in;
      choice_ff   <= choice_in;
      fade_sel_ff <= fade_sel_in;
      q_ff        <= q_in;
      fg_ff       <= fg_in;
      len_prod_ff <= len_prod_in;
      neg_ff      <= neg_in;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_OUT) && ctrl.out_free;
   assign stat.gain = cfg.mute ? '0 : gain_ff;

endmodule

// ----- hw/rtl/rbg_lane.sv -----
// One channel lane: sample times Q1.24 gain, floor shift
module rbg_lane (
   input  logic                                clock,
   input  logic signed [rbg_pkg::SAMPLE_W-1:0] sample,
   input  logic        [rbg_pkg::GAIN_W-1:0]   gain,
   output logic signed [rbg_pkg::SAMPLE_W-1:0] scaled
);

   logic signed [rbg_pkg::LANE_PROD_W-1:0] product_ff, product_in;

   assign product_in = rbg_pkg::LANE_PROD_W'(sample)
                       * rbg_pkg::LANE_PROD_W'($signed({1'b0, gain}));

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign scaled = product_ff[rbg_pkg::GAIN_FRAC_W+rbg_pkg::SAMPLE_W-1:rbg_pkg::GAIN_FRAC_W];

endmodule
